[hdl/mrl_pkg.sv]
// Shared types and constants of the masked route lookup unit.
package mrl_pkg;

	localparam int ADDR_W   = 16;
	localparam int METRIC_W = 8;
	localparam int IFACE_W  = 8;
	localparam int COUNT_W  = 6;
	localparam int INDEX_W  = 5;

	localparam logic [IFACE_W-1:0] NO_ROUTE_IFACE = 8'hFF;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_WRITE  = 1'b1
	} action_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   dest;
		logic [ADDR_W-1:0]   mask;
		logic [ADDR_W-1:0]   gateway;
		logic [METRIC_W-1:0] metric;
		logic [IFACE_W-1:0]  iface;
	} route_entry_t;

	// Partial lookup result handed from cell to cell.
	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic                found_local;
		logic                have_remote;
		logic [METRIC_W-1:0] best_metric;
		logic [IFACE_W-1:0]  best_iface;
	} lookup_data_t;

	typedef struct packed {
		logic adv;
		logic active;
	} cell_ctrl_t;

endpackage

[hdl/mrl_req_if.sv]
// Request channel of the masked route lookup unit.
interface mrl_req_if;
	import mrl_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [ADDR_W-1:0]   lookup_addr;
	logic [INDEX_W-1:0]  entry_index;
	logic [ADDR_W-1:0]   entry_dest;
	logic [ADDR_W-1:0]   entry_mask;
	logic [ADDR_W-1:0]   entry_gateway;
	logic [METRIC_W-1:0] entry_metric;
	logic [IFACE_W-1:0]  entry_iface;

	modport source (
		output valid, action, lookup_addr, entry_index, entry_dest, entry_mask,
			entry_gateway, entry_metric, entry_iface,
		input  ready
	);

	modport sink (
		input  valid, action, lookup_addr, entry_index, entry_dest, entry_mask,
			entry_gateway, entry_metric, entry_iface,
		output ready
	);
endinterface

[hdl/mrl_rsp_if.sv]
// Result channel of the masked route lookup unit.
interface mrl_rsp_if;
	import mrl_pkg::*;

	logic               valid;
	logic               ready;
	logic               hit;
	logic [IFACE_W-1:0] out_iface;
	logic               local_route;

	modport source (
		output valid, hit, out_iface, local_route,
		input  ready
	);

	modport sink (
		input  valid, hit, out_iface, local_route,
		output ready
	);
endinterface

[hdl/mrl_cell.sv]
// One route table cell: holds an entry and refines the passing lookup.
module mrl_cell import mrl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cell_ctrl_t   ctrl,
	input  logic         wr_en,
	input  route_entry_t wr_entry,
	input  logic         vld_in,
	input  lookup_data_t data_in,
	output logic         vld_out,
	output lookup_data_t data_out
);

	route_entry_t entry_q;
	logic         vld_s1;
	lookup_data_t data_s1;
	lookup_data_t data_nxt;
	logic         match;

	assign match = ((data_in.addr ^ entry_q.dest) & entry_q.mask) == '0;

	always_comb begin
		data_nxt = data_in;
		if (ctrl.active && !data_in.found_local && match) begin
			if (entry_q.gateway == '0) begin
				// first local match settles the lookup
				data_nxt.found_local = 1'b1;
				data_nxt.best_iface  = entry_q.iface;
			end else if (!data_in.have_remote || (entry_q.metric < data_in.best_metric)) begin
				data_nxt.have_remote = 1'b1;
				data_nxt.best_metric = entry_q.metric;
				data_nxt.best_iface  = entry_q.iface;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ctrl.adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			data_s1 <= data_nxt;
		end
	end

	assign vld_out  = vld_s1;
	assign data_out = data_s1;

endmodule

[hdl/masked_route_lookup_unit.sv]
// Top level of the masked route lookup unit: a chain of route table cells.
//
// The route table lives in a row of TABLE_DEPTH cells, one entry per cell. A write
// request stores its entry in the addressed cell and gives no result; writes to a
// slot at or beyond TABLE_DEPTH are dropped. A lookup request enters the first
// cell and moves one cell per cycle unless the chain holds; each cell among the
// first entries_in_use compares the address with its entry under the mask and
// updates the running answer (first local match wins, else first remote match of
// least metric). From the last cell the answer drops into the output register,
// and the next request is taken in the cycle after the result is registered. One
// lookup is in the chain at a time. If the result register is still full when a
// lookup reaches the end, the chain holds until the result is taken. Configure
// entries_in_use only while idle; cells never written must not be reached by a
// lookup.
module masked_route_lookup_unit import mrl_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	mrl_req_if.sink            req,
	mrl_rsp_if.source          rsp,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	logic [COUNT_W-1:0] count_q;
	logic               busy_q;
	logic               rsp_valid_q;
	logic               hit_q;
	logic [IFACE_W-1:0] iface_q;
	logic               local_q;

	logic               req_acc;
	logic               lookup_acc;
	logic               write_acc;
	logic               adv;
	logic               load_res;
	route_entry_t       wr_entry;

	logic               vld_chain  [0:TABLE_DEPTH];
	lookup_data_t       data_chain [0:TABLE_DEPTH];

	// Take a request only with the chain empty.
	assign req.ready  = !busy_q;
	assign req_acc    = req.valid && req.ready;
	assign lookup_acc = req_acc && (req.action == ACT_LOOKUP);
	assign write_acc  = req_acc && (req.action == ACT_WRITE);

	// Hold the whole chain while a finished lookup waits on a full result register.
	assign adv      = !(vld_chain[TABLE_DEPTH] && rsp_valid_q && !rsp.ready);
	assign load_res = vld_chain[TABLE_DEPTH] && adv;

	assign wr_entry = '{
		dest:    req.entry_dest,
		mask:    req.entry_mask,
		gateway: req.entry_gateway,
		metric:  req.entry_metric,
		iface:   req.entry_iface
	};

	// Inject a fresh lookup with no match recorded yet.
	assign vld_chain[0]  = lookup_acc;
	assign data_chain[0] = '{
		addr:        req.lookup_addr,
		found_local: 1'b0,
		have_remote: 1'b0,
		best_metric: '0,
		best_iface:  '0
	};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		logic       wr_sel;

		// Only entries below the configured count take part; counts beyond the
		// table saturate naturally since no cell sits past its end.
		assign ctrl.adv    = adv;
		assign ctrl.active = int'(count_q) > i;
		assign wr_sel      = write_acc && (int'(req.entry_index) == i);

		mrl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.wr_en    (wr_sel),
			.wr_entry (wr_entry),
			.vld_in   (vld_chain[i]),
			.data_in  (data_chain[i]),
			.vld_out  (vld_chain[i+1]),
			.data_out (data_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Busy from lookup acceptance until its answer is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (lookup_acc) begin
			busy_q <= 1'b1;
		end else if (load_res) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_res) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Resolve the answer: a miss reports the no-route interface.
	always_ff @(posedge clk) begin
		if (load_res) begin
			hit_q   <= data_chain[TABLE_DEPTH].found_local || data_chain[TABLE_DEPTH].have_remote;
			local_q <= data_chain[TABLE_DEPTH].found_local;
			if (data_chain[TABLE_DEPTH].found_local || data_chain[TABLE_DEPTH].have_remote) begin
				iface_q <= data_chain[TABLE_DEPTH].best_iface;
			end else begin
				iface_q <= NO_ROUTE_IFACE;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.out_iface   = iface_q;
	assign rsp.local_route = local_q;

endmodule
